// ----- hw/rtl/fat12ct_pkg.sv -----
package fat12ct_pkg;

  localparam int MAX_CLUSTERS_DEF = 4096;
  localparam int TABLE_BYTES_DEF  = 6144;

  localparam logic [11:0] ENT_BAD  = 12'hFF7;
  localparam logic [11:0] ENT_LAST = 12'hFFF;
  localparam logic [7:0]  NIB_LO   = 8'h0F;
  localparam logic [7:0]  NIB_HI   = 8'hF0;

  typedef enum logic [2:0] {
    CMD_GET   = 3'd0,
    CMD_SET   = 3'd1,
    CMD_ALLOC = 3'd2,
    CMD_FREE  = 3'd3,
    CMD_LOAD  = 3'd4,
    CMD_READ  = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_LOOP  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_CAPTURE,
    DP_RD_LO,
    DP_RD_HI,
    DP_LATCH_HI,
    DP_WR_LO,
    DP_WR_HI,
    DP_SCAN_NEXT,
    DP_WALK,
    DP_BYTE_WR,
    DP_BYTE_RD,
    DP_RESULT
  } dp_op_t;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_ENTRY,
    RES_GRANT,
    RES_BYTE
  } res_sel_t;

  typedef struct packed {
    dp_op_t   op;
    res_sel_t res_sel;
    status_t  status;
  } dp_ctl_t;

  typedef struct packed {
    cmd_t cmd;
    logic cl_ok;
    logic start_empty;
    logic scan_ok;
    logic entry_zero;
    logic entry_stop;
    logic cap_hit;
    logic addr_ok;
  } dp_stat_t;

  function automatic logic is_stop(input logic [11:0] v);
    return (v < 12'd2) || (v >= ENT_BAD);
  endfunction

endpackage

// ----- hw/rtl/fat12ct_ifs.sv -----
interface fat12ct_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [11:0] cluster;
  logic [11:0] new_value;
  logic [12:0] byte_addr;
  logic [7:0]  byte_in;

  modport source (output valid, cmd, cluster, new_value, byte_addr, byte_in, input ready);
  modport sink (input valid, cmd, cluster, new_value, byte_addr, byte_in, output ready);
endinterface

interface fat12ct_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] entry_value;
  logic        end_of_chain;
  logic [7:0]  byte_out;
  logic [1:0]  status;

  modport source (output valid, entry_value, end_of_chain, byte_out, status, input ready);
  modport sink (input valid, entry_value, end_of_chain, byte_out, status, output ready);
endinterface

interface fat12ct_cfg_if;
  logic        valid;
  logic        ready;
  logic [11:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ----- hw/rtl/fat12_cluster_table.sv -----
// FAT12 allocation table engine over a single-port packed byte RAM.
// in_chan carries one command transaction (get, set, allocate, free chain,
// load byte, read byte); out_chan returns exactly one result per command.
// cfg_chan writes cluster_count at any time it is valid (ready is always
// high); write it only while no command is in flight.
// Every RAM access is one byte per cycle. Get reads the entry's low and high
// bytes; set reads them, then writes low and high back. Allocate reads each
// cluster from 2 upward until a zero entry, which it sets to end of chain.
// Free chain reads and clears each entry of the chain in turn.
// The next command is accepted the cycle after a result is registered.
// The result register holds while out_chan.ready is low; one further command
// may be processed meanwhile and waits in its final state for the slot.
// Reset clears the controller, cluster_count and the walk registers; table
// contents are undefined until loaded through load byte or set.
module fat12_cluster_table #(
  parameter int MAX_CLUSTERS = fat12ct_pkg::MAX_CLUSTERS_DEF,
  parameter int TABLE_BYTES  = fat12ct_pkg::TABLE_BYTES_DEF
) (
  input logic           clk,
  input logic           rst_n,
  fat12ct_in_if.sink    in_chan,
  fat12ct_out_if.source out_chan,
  fat12ct_cfg_if.sink   cfg_chan
);

  fat12ct_pkg::dp_ctl_t  ctl;
  fat12ct_pkg::dp_stat_t stat;

  assign cfg_chan.ready = 1'b1;

  fat12ct_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  fat12ct_datapath #(
    .MAX_CLUSTERS (MAX_CLUSTERS),
    .TABLE_BYTES  (TABLE_BYTES)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (in_chan.cmd),
    .cluster      (in_chan.cluster),
    .new_value    (in_chan.new_value),
    .byte_addr    (in_chan.byte_addr),
    .byte_in      (in_chan.byte_in),
    .cfg_we       (cfg_chan.valid && cfg_chan.ready),
    .cfg_data     (cfg_chan.data),
    .ctl          (ctl),
    .stat         (stat),
    .entry_value  (out_chan.entry_value),
    .end_of_chain (out_chan.end_of_chain),
    .byte_out     (out_chan.byte_out),
    .status       (out_chan.status)
  );

  a_wr_pair: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.op == fat12ct_pkg::DP_WR_LO |=> ctl.op == fat12ct_pkg::DP_WR_HI)
    else $error("entry write low byte not followed by high byte");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> !in_chan.ready)
    else $error("new transaction accepted while command in flight");

  a_eoc_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.end_of_chain |-> out_chan.status == fat12ct_pkg::ST_OK)
    else $error("end of chain flagged on failing result");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.status != fat12ct_pkg::ST_OK
      |-> out_chan.entry_value == 12'd0 && out_chan.byte_out == 8'd0)
    else $error("failing result carries nonzero payload");

endmodule

// ----- hw/rtl/fat12ct_datapath.sv -----
module fat12ct_datapath #(
  parameter int MAX_CLUSTERS = fat12ct_pkg::MAX_CLUSTERS_DEF,
  parameter int TABLE_BYTES  = fat12ct_pkg::TABLE_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [2:0]           cmd,
  input  logic [11:0]          cluster,
  input  logic [11:0]          new_value,
  input  logic [12:0]          byte_addr,
  input  logic [7:0]           byte_in,
  input  logic                 cfg_we,
  input  logic [11:0]          cfg_data,
  input  fat12ct_pkg::dp_ctl_t ctl,
  output fat12ct_pkg::dp_stat_t stat,
  output logic [11:0]          entry_value,
  output logic                 end_of_chain,
  output logic [7:0]           byte_out,
  output logic [1:0]           status
);

  localparam int AW = $clog2(TABLE_BYTES);

  logic [7:0] mem [TABLE_BYTES];

  fat12ct_pkg::cmd_t    cmd_r;
  fat12ct_pkg::status_t status_r;
  logic [11:0] new_value_r;
  logic [12:0] byte_addr_r;
  logic [7:0]  byte_in_r;
  logic [11:0] count_r;
  logic [12:0] walk_pointer_r;
  logic [11:0] walk_steps_r;
  logic        walk_stop_r;
  logic [7:0]  lo_r;
  logic [7:0]  hi_r;
  logic [7:0]  rd_q_r;
  logic [11:0] entry_value_r;
  logic        end_of_chain_r;
  logic [7:0]  byte_out_r;

  logic [13:0]   at_lo;
  logic [13:0]   at_hi;
  logic [12:0]   limit;
  logic [11:0]   entry;
  logic [11:0]   wval;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata;
  logic          mem_we;
  logic          mem_re;

  assign at_lo = {1'b0, walk_pointer_r} + {2'b00, walk_pointer_r[12:1]};
  assign at_hi = at_lo + 14'd1;
  assign limit = {1'b0, count_r} + 13'd2;
  assign entry = walk_pointer_r[0] ? {hi_r, lo_r[7:4]} : {hi_r[3:0], lo_r};

  always_comb begin
    stat.cmd         = cmd_r;
    stat.cl_ok       = (walk_pointer_r < 13'(MAX_CLUSTERS)) && (at_hi < 14'(TABLE_BYTES));
    stat.start_empty = fat12ct_pkg::is_stop(walk_pointer_r[11:0]);
    stat.scan_ok     = stat.cl_ok && (walk_pointer_r < limit);
    stat.entry_zero  = (entry == 12'd0);
    stat.entry_stop  = walk_stop_r;
    stat.cap_hit     = (walk_steps_r >= count_r);
    stat.addr_ok     = ({1'b0, byte_addr_r} < 14'(TABLE_BYTES));
  end

  always_comb begin
    case (cmd_r)
      fat12ct_pkg::CMD_SET:   wval = new_value_r;
      fat12ct_pkg::CMD_ALLOC: wval = fat12ct_pkg::ENT_LAST;
      default:                wval = 12'd0;
    endcase
  end

  always_comb begin
    mem_addr  = at_lo[AW-1:0];
    mem_wdata = byte_in_r;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    unique case (ctl.op)
      fat12ct_pkg::DP_RD_LO: begin
        mem_re = 1'b1;
      end
      fat12ct_pkg::DP_RD_HI: begin
        mem_addr = at_hi[AW-1:0];
        mem_re   = 1'b1;
      end
      fat12ct_pkg::DP_WR_LO: begin
        mem_we    = 1'b1;
        mem_wdata = walk_pointer_r[0] ? ((lo_r & fat12ct_pkg::NIB_LO) | {wval[3:0], 4'h0})
                                      : wval[7:0];
      end
      fat12ct_pkg::DP_WR_HI: begin
        mem_addr  = at_hi[AW-1:0];
        mem_we    = 1'b1;
        mem_wdata = walk_pointer_r[0] ? wval[11:4]
                                      : ((hi_r & fat12ct_pkg::NIB_HI) | {4'h0, wval[11:8]});
      end
      fat12ct_pkg::DP_BYTE_WR: begin
        mem_addr = byte_addr_r[AW-1:0];
        mem_we   = 1'b1;
      end
      fat12ct_pkg::DP_BYTE_RD: begin
        mem_addr = byte_addr_r[AW-1:0];
        mem_re   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q_r <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r        <= 12'd0;
      walk_pointer_r <= 13'd0;
      walk_steps_r   <= 12'd0;
      walk_stop_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        count_r <= cfg_data;
      end
      case (ctl.op)
        fat12ct_pkg::DP_CAPTURE: begin
          walk_pointer_r <= (fat12ct_pkg::cmd_t'(cmd) == fat12ct_pkg::CMD_ALLOC) ? 13'd2
                                                                                 : {1'b0, cluster};
          walk_steps_r   <= 12'd0;
        end
        fat12ct_pkg::DP_SCAN_NEXT: begin
          walk_pointer_r <= walk_pointer_r + 13'd1;
        end
        fat12ct_pkg::DP_WALK: begin
          walk_steps_r <= walk_steps_r + 12'd1;
          walk_stop_r  <= fat12ct_pkg::is_stop(entry);
          if (!fat12ct_pkg::is_stop(entry)) begin
            walk_pointer_r <= {1'b0, entry};
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      fat12ct_pkg::DP_CAPTURE: begin
        cmd_r       <= fat12ct_pkg::cmd_t'(cmd);
        new_value_r <= new_value;
        byte_addr_r <= byte_addr;
        byte_in_r   <= byte_in;
      end
      fat12ct_pkg::DP_RD_HI: begin
        lo_r <= rd_q_r;
      end
      fat12ct_pkg::DP_LATCH_HI: begin
        hi_r <= rd_q_r;
      end
      fat12ct_pkg::DP_RESULT: begin
        status_r       <= ctl.status;
        entry_value_r  <= 12'd0;
        end_of_chain_r <= 1'b0;
        byte_out_r     <= 8'd0;
        case (ctl.res_sel)
          fat12ct_pkg::RES_ENTRY: begin
            entry_value_r  <= entry;
            end_of_chain_r <= (entry >= fat12ct_pkg::ENT_BAD);
          end
          fat12ct_pkg::RES_GRANT: entry_value_r <= walk_pointer_r[11:0];
          fat12ct_pkg::RES_BYTE:  byte_out_r <= rd_q_r;
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  assign entry_value  = entry_value_r;
  assign end_of_chain = end_of_chain_r;
  assign byte_out     = byte_out_r;
  assign status       = status_r;

endmodule

// ----- hw/rtl/fat12ct_ctrl.sv -----
module fat12ct_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  fat12ct_pkg::dp_stat_t stat,
  output fat12ct_pkg::dp_ctl_t  ctl
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_RD_LO,
    S_RD_HI,
    S_LATCH,
    S_DECIDE,
    S_WR_LO,
    S_WR_HI,
    S_SCAN_CHK,
    S_WALK,
    S_WALK_CHK,
    S_FINISH
  } state_t;

  state_t                state_r, state_nxt;
  fat12ct_pkg::res_sel_t res_sel_r, res_sel_nxt;
  fat12ct_pkg::status_t  st_r, st_nxt;
  logic                  out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    res_sel_nxt   = res_sel_r;
    st_nxt        = st_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ctl.op        = fat12ct_pkg::DP_NOP;
    ctl.res_sel   = res_sel_r;
    ctl.status    = st_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.op    = fat12ct_pkg::DP_CAPTURE;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        res_sel_nxt = fat12ct_pkg::RES_NONE;
        st_nxt      = fat12ct_pkg::ST_OK;
        state_nxt   = S_FINISH;
        unique case (stat.cmd) inside
          fat12ct_pkg::CMD_GET, fat12ct_pkg::CMD_SET: begin
            if (stat.cl_ok) state_nxt = S_RD_LO;
            else st_nxt = fat12ct_pkg::ST_RANGE;
          end
          fat12ct_pkg::CMD_ALLOC: begin
            if (stat.scan_ok) state_nxt = S_RD_LO;
            else st_nxt = fat12ct_pkg::ST_FULL;
          end
          fat12ct_pkg::CMD_FREE: begin
            if (stat.start_empty) st_nxt = fat12ct_pkg::ST_OK;
            else if (!stat.cl_ok) st_nxt = fat12ct_pkg::ST_RANGE;
            else if (stat.cap_hit) st_nxt = fat12ct_pkg::ST_LOOP;
            else state_nxt = S_RD_LO;
          end
          fat12ct_pkg::CMD_LOAD: begin
            if (stat.addr_ok) ctl.op = fat12ct_pkg::DP_BYTE_WR;
            else st_nxt = fat12ct_pkg::ST_RANGE;
          end
          fat12ct_pkg::CMD_READ: begin
            if (stat.addr_ok) begin
              ctl.op      = fat12ct_pkg::DP_BYTE_RD;
              res_sel_nxt = fat12ct_pkg::RES_BYTE;
            end else begin
              st_nxt = fat12ct_pkg::ST_RANGE;
            end
          end
          default: begin
          end
        endcase
      end
      S_RD_LO: begin
        ctl.op    = fat12ct_pkg::DP_RD_LO;
        state_nxt = S_RD_HI;
      end
      S_RD_HI: begin
        ctl.op    = fat12ct_pkg::DP_RD_HI;
        state_nxt = S_LATCH;
      end
      S_LATCH: begin
        ctl.op    = fat12ct_pkg::DP_LATCH_HI;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        unique case (stat.cmd) inside
          fat12ct_pkg::CMD_GET: begin
            res_sel_nxt = fat12ct_pkg::RES_ENTRY;
            state_nxt   = S_FINISH;
          end
          fat12ct_pkg::CMD_ALLOC: begin
            if (stat.entry_zero) begin
              state_nxt = S_WR_LO;
            end else begin
              ctl.op    = fat12ct_pkg::DP_SCAN_NEXT;
              state_nxt = S_SCAN_CHK;
            end
          end
          fat12ct_pkg::CMD_SET, fat12ct_pkg::CMD_FREE: begin
            state_nxt = S_WR_LO;
          end
          default: begin
            state_nxt = S_FINISH;
          end
        endcase
      end
      S_WR_LO: begin
        ctl.op    = fat12ct_pkg::DP_WR_LO;
        state_nxt = S_WR_HI;
      end
      S_WR_HI: begin
        ctl.op    = fat12ct_pkg::DP_WR_HI;
        state_nxt = S_FINISH;
        if (stat.cmd == fat12ct_pkg::CMD_ALLOC) res_sel_nxt = fat12ct_pkg::RES_GRANT;
        if (stat.cmd == fat12ct_pkg::CMD_FREE) state_nxt = S_WALK;
      end
      S_SCAN_CHK: begin
        if (stat.scan_ok) begin
          state_nxt = S_RD_LO;
        end else begin
          st_nxt    = fat12ct_pkg::ST_FULL;
          state_nxt = S_FINISH;
        end
      end
      S_WALK: begin
        ctl.op    = fat12ct_pkg::DP_WALK;
        state_nxt = S_WALK_CHK;
      end
      S_WALK_CHK: begin
        state_nxt = S_FINISH;
        if (stat.entry_stop) st_nxt = fat12ct_pkg::ST_OK;
        else if (!stat.cl_ok) st_nxt = fat12ct_pkg::ST_RANGE;
        else if (stat.cap_hit) st_nxt = fat12ct_pkg::ST_LOOP;
        else state_nxt = S_RD_LO;
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          ctl.op        = fat12ct_pkg::DP_RESULT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      res_sel_r   <= fat12ct_pkg::RES_NONE;
      st_r        <= fat12ct_pkg::ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      res_sel_r   <= res_sel_nxt;
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ----- tb/fat12_cluster_table_tb.sv -----
module fat12_cluster_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_CLUSTERS = fat12ct_pkg::MAX_CLUSTERS_DEF;
  localparam int TABLE_BYTES  = fat12ct_pkg::TABLE_BYTES_DEF;
  localparam int CLK_PERIOD   = 10;
  localparam int CYCLE_LIMIT  = 10000000;
  localparam int RANDOM_ITEMS = 1700;
  localparam int CALM_ITEMS   = 200;
  localparam int LOW_CLUSTERS = 64;
  localparam int TOP_FIRST    = 4080;
  localparam int LOW_BYTES    = LOW_CLUSTERS * 3 / 2;
  localparam int TOP_BYTE     = TOP_FIRST * 3 / 2;

  localparam logic [2:0]  CMD_RSV6  = 3'd6;
  localparam logic [2:0]  CMD_RSV7  = 3'd7;
  localparam logic [11:0] COUNT_MAX = 12'd4094;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [11:0] cluster;
    logic [11:0] new_value;
    logic [12:0] byte_addr;
    logic [7:0]  byte_in;
  } fat_cmd_t;

  typedef struct packed {
    logic [11:0]          entry_value;
    logic                 end_of_chain;
    logic [7:0]           byte_out;
    fat12ct_pkg::status_t status;
  } fat_result_t;

  class alloc_table_model;
    byte unsigned tbl [TABLE_BYTES];
    bit           known [TABLE_BYTES];
    logic [11:0]  clusters;
    logic [11:0]  walk_ptr;
    logic [11:0]  walk_cnt;
    bit           dry;
    bit           stray;
    fat_result_t  due_results [$];
    int           errors;
    int           seen;

    function new();
      foreach (tbl[i]) begin
        tbl[i]   = 8'h00;
        known[i] = 1'b0;
      end
      clusters = '0;
      walk_ptr = '0;
      walk_cnt = '0;
      dry      = 1'b0;
      stray    = 1'b0;
      errors   = 0;
      seen     = 0;
    endfunction

    function logic [7:0] peek(int a);
      if (!known[a]) stray = 1'b1;
      return tbl[a];
    endfunction

    function void poke(int a, logic [7:0] v);
      if (dry) return;
      tbl[a]   = v;
      known[a] = 1'b1;
    endfunction

    function bit fits(int c);
      return c < MAX_CLUSTERS && c + c / 2 + 1 < TABLE_BYTES;
    endfunction

    function logic [11:0] entry_get(int c);
      int         at;
      logic [7:0] lo;
      logic [7:0] hi;
      at = c + c / 2;
      lo = peek(at);
      hi = peek(at + 1);
      if (c % 2 == 1) return {hi, lo[7:4]};
      return {hi[3:0], lo};
    endfunction

    function void entry_put(int c, logic [11:0] v);
      int         at;
      logic [7:0] old;
      at = c + c / 2;
      if (c % 2 == 1) begin
        old = peek(at);
        poke(at, {v[3:0], old[3:0]});
        poke(at + 1, v[11:4]);
      end else begin
        old = peek(at + 1);
        poke(at, v[7:0]);
        poke(at + 1, {old[7:4], v[11:8]});
      end
    endfunction

    function bit stops_walk(logic [11:0] v);
      return v < 12'd2 || v >= fat12ct_pkg::ENT_BAD;
    endfunction

    function fat_result_t apply(fat_cmd_t t);
      fat_result_t r;
      int          cur;
      int          steps;
      logic [11:0] nxt;
      r = '0;
      case (t.cmd)
        fat12ct_pkg::CMD_GET: begin
          if (!fits(int'(t.cluster))) begin
            r.status = fat12ct_pkg::ST_RANGE;
          end else begin
            r.entry_value  = entry_get(int'(t.cluster));
            r.end_of_chain = r.entry_value >= fat12ct_pkg::ENT_BAD;
          end
        end
        fat12ct_pkg::CMD_SET: begin
          if (!fits(int'(t.cluster))) r.status = fat12ct_pkg::ST_RANGE;
          else entry_put(int'(t.cluster), t.new_value);
        end
        fat12ct_pkg::CMD_ALLOC: begin
          r.status = fat12ct_pkg::ST_FULL;
          for (cur = 2; cur < clusters + 2 && fits(cur); cur++) begin
            if (entry_get(cur) == 12'd0) begin
              entry_put(cur, fat12ct_pkg::ENT_LAST);
              r.entry_value = cur[11:0];
              r.status      = fat12ct_pkg::ST_OK;
              break;
            end
          end
        end
        fat12ct_pkg::CMD_FREE: begin
          cur   = int'(t.cluster);
          steps = 0;
          if (stops_walk(t.cluster)) begin
          end else if (!fits(cur)) begin
            r.status = fat12ct_pkg::ST_RANGE;
          end else begin
            forever begin
              if (steps >= clusters) begin
                r.status = fat12ct_pkg::ST_LOOP;
                break;
              end
              nxt = entry_get(cur);
              entry_put(cur, 12'd0);
              steps++;
              if (stops_walk(nxt)) break;
              cur = int'(nxt);
              if (!fits(cur)) begin
                r.status = fat12ct_pkg::ST_RANGE;
                break;
              end
            end
            if (!dry) begin
              walk_ptr = cur[11:0];
              walk_cnt = steps[11:0];
            end
          end
        end
        fat12ct_pkg::CMD_LOAD: begin
          if (t.byte_addr < TABLE_BYTES) poke(int'(t.byte_addr), t.byte_in);
          else r.status = fat12ct_pkg::ST_RANGE;
        end
        fat12ct_pkg::CMD_READ: begin
          if (t.byte_addr < TABLE_BYTES) r.byte_out = peek(int'(t.byte_addr));
          else r.status = fat12ct_pkg::ST_RANGE;
        end
        default: r = '0;
      endcase
      return r;
    endfunction

    // true when the command would read a table byte never written
    function bit would_stray(fat_cmd_t t);
      fat_result_t r;
      dry   = 1'b1;
      stray = 1'b0;
      r     = apply(t);
      dry   = 1'b0;
      return stray;
    endfunction

    function void note_command(fat_cmd_t t);
      due_results.push_back(apply(t));
    endfunction

    task flag_error(string msg);
      $display("MISMATCH at result %0d: %s", seen, msg);
      errors++;
    endtask

    task check_result(logic [11:0] ev, logic eoc, logic [7:0] bo, logic [1:0] st);
      fat_result_t e;
      seen++;
      if (due_results.size() == 0) begin
        flag_error($sformatf("unexpected transaction entry %03h status %0d", ev, st));
        return;
      end
      e = due_results.pop_front();
      if (ev !== e.entry_value)
        flag_error($sformatf("entry_value %03h, expected %03h", ev, e.entry_value));
      if (eoc !== e.end_of_chain)
        flag_error($sformatf("end_of_chain %b, expected %b", eoc, e.end_of_chain));
      if (bo !== e.byte_out)
        flag_error($sformatf("byte_out %02h, expected %02h", bo, e.byte_out));
      if (st !== e.status)
        flag_error($sformatf("status %0d, expected %0d", st, e.status));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   idling_on;
  int   stall_left;
  int   cycles;
  int   issued;

  alloc_table_model tbl_model = new();

  fat12ct_in_if  in_if ();
  fat12ct_out_if out_if ();
  fat12ct_cfg_if cfg_if ();

  fat12_cluster_table dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (!idling_on) begin
      stall_left = 0;
      out_if.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left = int'($urandom_range(1, 19)) - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      tbl_model.check_result(out_if.entry_value, out_if.end_of_chain, out_if.byte_out,
                             out_if.status);
  end

  function automatic logic [11:0] pick_cluster();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 12'($urandom_range(0, LOW_CLUSTERS - 1));
    if (p < 80) return 12'($urandom_range(TOP_FIRST, MAX_CLUSTERS - 1));
    if (p < 90) return 12'($urandom_range(fat12ct_pkg::ENT_BAD, 12'hFFF));
    return 12'($urandom_range(0, 4095));
  endfunction

  function automatic logic [11:0] pick_entry();
    int p;
    p = $urandom_range(0, 99);
    if (p < 30) return 12'd0;
    if (p < 65) return 12'($urandom_range(2, LOW_CLUSTERS - 1));
    if (p < 75) return 12'($urandom_range(TOP_FIRST, MAX_CLUSTERS - 1));
    if (p < 90) return 12'($urandom_range(fat12ct_pkg::ENT_BAD, 12'hFFF));
    return 12'($urandom_range(0, 4095));
  endfunction

  function automatic logic [12:0] pick_addr();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 13'($urandom_range(0, LOW_BYTES - 1));
    if (p < 75) return 13'($urandom_range(TOP_BYTE, TABLE_BYTES - 1));
    if (p < 85) return 13'($urandom_range(TABLE_BYTES, 8191));
    return 13'($urandom_range(0, 8191));
  endfunction

  function automatic logic [7:0] pick_byte();
    if ($urandom_range(0, 9) < 3) return 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic fat_cmd_t draw_cmd();
    fat_cmd_t t;
    int       p;
    int       tries;
    for (tries = 0; tries < 16; tries++) begin
      t.cluster   = pick_cluster();
      t.new_value = pick_entry();
      t.byte_addr = pick_addr();
      t.byte_in   = pick_byte();
      p = $urandom_range(0, 99);
      if (p < 20) t.cmd = fat12ct_pkg::CMD_GET;
      else if (p < 42) t.cmd = fat12ct_pkg::CMD_SET;
      else if (p < 56) t.cmd = fat12ct_pkg::CMD_ALLOC;
      else if (p < 72) t.cmd = fat12ct_pkg::CMD_FREE;
      else if (p < 82) t.cmd = fat12ct_pkg::CMD_LOAD;
      else if (p < 96) t.cmd = fat12ct_pkg::CMD_READ;
      else t.cmd = p[0] ? CMD_RSV7 : CMD_RSV6;
      if (!tbl_model.would_stray(t)) return t;
    end
    t.cmd       = fat12ct_pkg::CMD_LOAD;
    t.byte_addr = 13'($urandom_range(0, LOW_BYTES - 1));
    return t;
  endfunction

  task automatic push_cmd(fat_cmd_t t);
    int gap;
    @(negedge clk);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      gap = int'($urandom_range(1, 19));
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.cmd       <= t.cmd;
    in_if.cluster   <= t.cluster;
    in_if.new_value <= t.new_value;
    in_if.byte_addr <= t.byte_addr;
    in_if.byte_in   <= t.byte_in;
    do @(posedge clk); while (!in_if.ready);
    tbl_model.note_command(t);
    if (t.cmd <= fat12ct_pkg::CMD_READ) issued++;
  endtask

  task automatic issue(logic [2:0] cmd, logic [11:0] cl, logic [11:0] nv, logic [12:0] addr,
                       logic [7:0] bin);
    fat_cmd_t t;
    t.cmd       = cmd;
    t.cluster   = cl;
    t.new_value = nv;
    t.byte_addr = addr;
    t.byte_in   = bin;
    push_cmd(t);
  endtask

  task automatic drain();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (tbl_model.due_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_cluster_count(logic [11:0] v);
    drain();
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    do @(posedge clk); while (!cfg_if.ready);
    tbl_model.clusters = v;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // load whole entry pairs of random values so that every byte of the span is defined
  task automatic format_span(int first, int pairs);
    logic [11:0] a;
    logic [11:0] b;
    int          at;
    for (int k = 0; k < pairs; k++) begin
      a  = pick_entry();
      b  = pick_entry();
      at = first + first / 2 + 3 * k;
      issue(fat12ct_pkg::CMD_LOAD, pick_cluster(), pick_entry(), 13'(at), a[7:0]);
      issue(fat12ct_pkg::CMD_LOAD, pick_cluster(), pick_entry(), 13'(at + 1),
            {b[3:0], a[11:8]});
      issue(fat12ct_pkg::CMD_LOAD, pick_cluster(), pick_entry(), 13'(at + 2), b[11:4]);
    end
  endtask

  initial begin
    logic [11:0] count;
    int          phase;
    int          plen;
    rst_n           = 1'b0;
    idling_on       = 1'b1;
    stall_left      = 0;
    cycles          = 0;
    issued          = 0;
    in_if.valid     = 1'b0;
    in_if.cmd       = '0;
    in_if.cluster   = '0;
    in_if.new_value = '0;
    in_if.byte_addr = '0;
    in_if.byte_in   = '0;
    out_if.ready    = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.data     = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_cluster_count(12'd0);
    issue(fat12ct_pkg::CMD_LOAD, 12'd0, 12'd0, 13'd6143, 8'hAB);
    issue(fat12ct_pkg::CMD_LOAD, 12'd0, 12'd0, 13'd6142, 8'hCD);
    issue(fat12ct_pkg::CMD_LOAD, 12'd0, 12'd0, 13'd6141, 8'hEF);
    issue(fat12ct_pkg::CMD_GET, 12'd4095, 12'd0, 13'd0, 8'h00);
    issue(fat12ct_pkg::CMD_GET, 12'd4094, 12'd0, 13'd0, 8'h00);
    issue(fat12ct_pkg::CMD_READ, 12'd0, 12'd0, 13'd6143, 8'h00);
    issue(fat12ct_pkg::CMD_LOAD, 12'd0, 12'd0, 13'd6144, 8'h5A);
    issue(fat12ct_pkg::CMD_LOAD, 12'd0, 12'd0, 13'd8191, 8'hFF);
    issue(fat12ct_pkg::CMD_READ, 12'd0, 12'd0, 13'd8191, 8'h00);
    issue(fat12ct_pkg::CMD_SET, 12'd4095, fat12ct_pkg::ENT_BAD, 13'd0, 8'h00);
    issue(fat12ct_pkg::CMD_GET, 12'd4095, 12'd0, 13'd0, 8'h00);
    issue(fat12ct_pkg::CMD_SET, 12'd4094, 12'hFF8, 13'd0, 8'h00);
    issue(fat12ct_pkg::CMD_GET, 12'd4094, 12'd0, 13'd0, 8'h00);
    issue(fat12ct_pkg::CMD_SET, 12'd4095, 12'hFF6, 13'd0, 8'h00);
    issue(fat12ct_pkg::CMD_GET, 12'd4095, 12'd0, 13'd0, 8'h00);
    issue(fat12ct_pkg::CMD_SET, 12'd4094, 12'd0, 13'd0, 8'h00);
    issue(fat12ct_pkg::CMD_GET, 12'd4094, 12'd0, 13'd0, 8'h00);
    issue(fat12ct_pkg::CMD_ALLOC, 12'd0, 12'd0, 13'd0, 8'h00);
    issue(fat12ct_pkg::CMD_FREE, 12'd0, 12'd0, 13'd0, 8'h00);
    issue(fat12ct_pkg::CMD_FREE, 12'd1, 12'd0, 13'd0, 8'h00);
    issue(fat12ct_pkg::CMD_FREE, fat12ct_pkg::ENT_BAD, 12'd0, 13'd0, 8'h00);
    issue(fat12ct_pkg::CMD_FREE, fat12ct_pkg::ENT_LAST, 12'd0, 13'd0, 8'h00);
    issue(fat12ct_pkg::CMD_FREE, 12'd4095, 12'd0, 13'd0, 8'h00);
    issue(CMD_RSV6, 12'hFFF, 12'hFFF, 13'h1FFF, 8'hFF);
    issue(CMD_RSV7, 12'hFFF, 12'hFFF, 13'h1FFF, 8'hFF);

    issued = 0;
    format_span(0, LOW_CLUSTERS / 2);
    format_span(TOP_FIRST, (MAX_CLUSTERS - TOP_FIRST) / 2);

    phase = 0;
    while (issued < RANDOM_ITEMS) begin
      if (phase == 0) count = COUNT_MAX;
      else if (phase == 1) count = 12'd0;
      else if ($urandom_range(0, 5) == 0) count = COUNT_MAX - 12'($urandom_range(0, 1));
      else if ($urandom_range(0, 4) == 0) count = 12'($urandom_range(0, 3));
      else count = 12'($urandom_range(0, 70));
      set_cluster_count(count);
      idling_on = $urandom_range(0, 3) != 0;
      if (phase > 1 && $urandom_range(0, 4) == 0) format_span(0, LOW_CLUSTERS / 2);
      plen = $urandom_range(40, 150);
      for (int n = 0; n < plen && issued < RANDOM_ITEMS; n++) begin
        if (issued >= RANDOM_ITEMS - CALM_ITEMS) idling_on = 1'b0;
        push_cmd(draw_cmd());
      end
      phase++;
    end

    drain();
    repeat (20) @(posedge clk);
    if (tbl_model.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
